// ===== design/dsr_pkg.sv =====
// shared types and constants for the decimal square root block
package dsr_pkg;

	localparam int RADICAND_BITS_DEF = 24;
	localparam int MAX_DIGITS_DEF    = 6;
	localparam int DIGITS_W          = 3;
	localparam int IN_TDATA_W        = 32;
	localparam int ROOT_BITS         = 32;
	localparam int VAL_BITS          = 2 * ROOT_BITS;
	localparam int REM_BITS          = ROOT_BITS + 2;
	localparam int CNT_W             = $clog2(ROOT_BITS);

	typedef struct packed {
		logic load;
		logic scale_step;
		logic root_step;
		logic out_load;
	} dsr_cmd_t;

	typedef struct packed {
		logic scale_done;
	} dsr_stat_t;

endpackage

// ===== design/dsr_datapath.sv =====
// datapath: decimal scaling by 100 and a restoring bit-pair square root
module dsr_datapath #(
	parameter int RADICAND_BITS = dsr_pkg::RADICAND_BITS_DEF,
	parameter int MAX_DIGITS    = dsr_pkg::MAX_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic [dsr_pkg::IN_TDATA_W-1:0]    in_data,
	input  dsr_pkg::dsr_cmd_t                 cmd,
	output dsr_pkg::dsr_stat_t                stat,
	output logic [dsr_pkg::ROOT_BITS-1:0]     root_out
);

	logic [RADICAND_BITS-1:0]          radicand;
	logic [dsr_pkg::DIGITS_W-1:0]      digits_in;
	logic [dsr_pkg::DIGITS_W-1:0]      digits_sat;
	logic [dsr_pkg::DIGITS_W-1:0]      digits_q;
	logic [dsr_pkg::VAL_BITS-1:0]      val_q;
	logic [dsr_pkg::VAL_BITS-1:0]      val_x100;
	logic [dsr_pkg::REM_BITS-1:0]      rem_q;
	logic [dsr_pkg::ROOT_BITS-1:0]     root_q;
	logic [dsr_pkg::REM_BITS+1:0]      rem_next;
	logic [dsr_pkg::REM_BITS+1:0]      trial;
	logic [dsr_pkg::REM_BITS+1:0]      diff;
	logic                              ge;

	assign radicand   = in_data[RADICAND_BITS-1:0];
	assign digits_in  = in_data[24 +: dsr_pkg::DIGITS_W];
	assign digits_sat = (digits_in > dsr_pkg::DIGITS_W'(MAX_DIGITS)) ?
		dsr_pkg::DIGITS_W'(MAX_DIGITS) : digits_in;

	// 100 * v = 64v + 32v + 4v
	assign val_x100 = (val_q << 6) + (val_q << 5) + (val_q << 2);

	assign rem_next = {rem_q, val_q[dsr_pkg::VAL_BITS-1 -: 2]};
	assign trial    = (dsr_pkg::REM_BITS+2)'({root_q, 2'b01});
	assign ge       = (rem_next >= trial);
	assign diff     = rem_next - trial;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q    <= dsr_pkg::VAL_BITS'(radicand);
			digits_q <= digits_sat;
			rem_q    <= '0;
			root_q   <= '0;
		end else if (cmd.scale_step) begin
			val_q    <= val_x100;
			digits_q <= digits_q - 1'b1;
		end else if (cmd.root_step) begin
			val_q  <= val_q << 2;
			rem_q  <= ge ? diff[dsr_pkg::REM_BITS-1:0] : rem_next[dsr_pkg::REM_BITS-1:0];
			root_q <= {root_q[dsr_pkg::ROOT_BITS-2:0], ge};
		end
		if (cmd.out_load) begin
			root_out <= root_q;
		end
	end

	assign stat.scale_done = (digits_q == '0);

endmodule

// ===== design/dsr_ctrl.sv =====
// controller: sequences load, scaling, root iterations and output handoff
module dsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  dsr_pkg::dsr_stat_t stat,
	output dsr_pkg::dsr_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ROOT,
		ST_HOLD
	} state_t;

	state_t                    state_q;
	logic [dsr_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      out_free;
	logic                      root_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign root_last = (cnt_q == dsr_pkg::CNT_W'(dsr_pkg::ROOT_BITS - 1));

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load       = in_valid;
			ST_SCALE: cmd.scale_step = !stat.scale_done;
			ST_ROOT:  cmd.root_step  = 1'b1;
			ST_HOLD:  cmd.out_load   = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (stat.scale_done) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (root_last) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/decimal_square_root_top.sv =====
// top level of the decimal square root block
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: radicand[23:0], digits[26:24], zero fill to 32
// m_axis   out  tdata: root_scaled[31:0]
//
// after accept, an item is scaled by 100 once per digit (digits capped at MAX_DIGITS), then runs 32 root iterations:
// one multiply by 100 per cycle, then one root bit per cycle in the restoring loop
// arst_n clears the controller and output valid; payload registers are not reset
// the result sits in an output register, so the next beat is taken while it waits
// a stalled result holds the last iteration until the output register frees
module decimal_square_root_top #(
	parameter int RADICAND_BITS = dsr_pkg::RADICAND_BITS_DEF,
	parameter int MAX_DIGITS    = dsr_pkg::MAX_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dsr_pkg::IN_TDATA_W-1:0] s_tdata,  // radicand, digits
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dsr_pkg::ROOT_BITS-1:0]  m_tdata   // root_scaled
);

	dsr_pkg::dsr_cmd_t  cmd;
	dsr_pkg::dsr_stat_t stat;

	dsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dsr_datapath #(
		.RADICAND_BITS (RADICAND_BITS),
		.MAX_DIGITS    (MAX_DIGITS)
	) u_datapath (
		.clk      (clk),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.root_out (m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after accept");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending beat");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("output valid without a result load");
`endif

endmodule
